### rtl/core/tre_pkg.sv
`default_nettype none

package tre_pkg;

  typedef logic [2:0] op_t;

  localparam op_t OP_RESET      = 3'd0;
  localparam op_t OP_TRANSMIT   = 3'd1;
  localparam op_t OP_ACK        = 3'd2;
  localparam op_t OP_TIMEOUT    = 3'd3;
  localparam op_t OP_RETRANSMIT = 3'd4;
  localparam op_t OP_FLIGHT_ACK = 3'd5;

  typedef logic [1:0] reg_index_t;

  localparam reg_index_t REG_TS_ENABLED  = 2'd0;
  localparam reg_index_t REG_RTO_MIN     = 2'd1;
  localparam reg_index_t REG_RTO_MAX     = 2'd2;
  localparam reg_index_t REG_RTO_INITIAL = 2'd3;

  localparam logic [31:0] RTO_MIN_RESET     = 32'd1000;
  localparam logic [31:0] RTO_MAX_RESET     = 32'd60000;
  localparam logic [31:0] RTO_INITIAL_RESET = 32'd1000;

  // when the bounds cross, min wins for values below min and max wins for all others
  function automatic logic [31:0] clamp_rto(input logic [34:0] v,
                                            input logic [31:0] lo,
                                            input logic [31:0] hi);
    logic [31:0] r;
    if (v < {3'b000, lo}) begin
      r = lo;
    end else if (v > {3'b000, hi}) begin
      r = hi;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/tcp_rto_estimator_unit.sv
// RTT / RTO estimator with timestamp probes and Karn suppression.
// An accepted item is held in the input register, then the state update loads
// the result register.
// Throughput: one event per cycle unless result_stall holds the result register; the state loop is not pipelined.
// Reset (rst, synchronous): config registers to their defaults, SRTT/RTTVAR 0,
// RTO 1000 ms, no probe, no suppression, pipeline empty.
`default_nettype none

module tcp_rto_estimator_unit (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        cfg_write_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,

  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [2:0]  operation,
  input  wire logic [31:0] segment_end_seq,
  input  wire logic [31:0] segment_tsval,
  input  wire logic [31:0] ack_number,
  input  wire logic        echo_present,
  input  wire logic [31:0] echo_tsecr,
  input  wire logic [31:0] now_ms,

  output logic             result_valid,
  input  wire logic        result_stall,
  output logic             sample_taken,
  output logic [31:0]      rto_out_ms,
  output logic [31:0]      srtt_out_ms,
  output logic [31:0]      rttvar_out_ms,
  output logic             in_retransmit,
  output logic             probe_armed
);

  // configuration
  logic        timestamps_enabled;
  logic [31:0] rto_min_ms;
  logic [31:0] rto_max_ms;
  logic [31:0] rto_initial_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      timestamps_enabled <= 1'b1;
      rto_min_ms         <= tre_pkg::RTO_MIN_RESET;
      rto_max_ms         <= tre_pkg::RTO_MAX_RESET;
      rto_initial_ms     <= tre_pkg::RTO_INITIAL_RESET;
    end else if (cfg_write_en) begin
      case (tre_pkg::reg_index_t'(cfg_index))
        tre_pkg::REG_TS_ENABLED:  timestamps_enabled <= cfg_data[0];
        tre_pkg::REG_RTO_MIN:     rto_min_ms         <= cfg_data;
        tre_pkg::REG_RTO_MAX:     rto_max_ms         <= cfg_data;
        tre_pkg::REG_RTO_INITIAL: rto_initial_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic              s1_valid;
  tre_pkg::op_t      s1_op;
  logic [31:0]       s1_end_seq;
  logic [31:0]       s1_tsval;
  logic [31:0]       s1_ack;
  logic              s1_echo;
  logic [31:0]       s1_tsecr;
  logic [31:0]       s1_now;
  logic              advance;

  assign advance    = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_op      <= operation;
      s1_end_seq <= segment_end_seq;
      s1_tsval   <= segment_tsval;
      s1_ack     <= ack_number;
      s1_echo    <= echo_present;
      s1_tsecr   <= echo_tsecr;
      s1_now     <= now_ms;
    end
  end

  // estimator state
  logic [31:0] smoothed_rtt;
  logic [31:0] rtt_variance;
  logic [31:0] timeout_value;
  logic        probe_valid;
  logic [31:0] probe_end_sequence;
  logic [31:0] probe_timestamp;
  logic        retransmitting;

  logic [31:0] smoothed_rtt_next;
  logic [31:0] rtt_variance_next;
  logic [31:0] timeout_value_next;
  logic        probe_valid_next;
  logic [31:0] probe_end_sequence_next;
  logic [31:0] probe_timestamp_next;
  logic        retransmitting_next;
  logic        took;

  logic [31:0] seq_delta;
  logic        ack_ok;
  logic [31:0] raw_sample;
  logic [31:0] sample;
  logic [31:0] diff;
  logic [34:0] var_sum;
  logic [34:0] srtt_sum;
  logic [31:0] srtt_upd;
  logic [31:0] var_upd;
  logic [34:0] rto_sum;
  logic [34:0] rto_double;

  always_comb begin
    seq_delta  = s1_ack - probe_end_sequence;
    ack_ok     = timestamps_enabled && s1_echo && probe_valid && !retransmitting
                 && (s1_tsecr == probe_timestamp) && !seq_delta[31];
    raw_sample = s1_now - s1_tsecr;
    sample     = (raw_sample == 32'd0) ? 32'd1 : raw_sample;
    diff       = (smoothed_rtt > sample) ? smoothed_rtt - sample
                                         : sample - smoothed_rtt;
    var_sum    = {1'b0, rtt_variance, 2'b00} - {3'b000, rtt_variance}
                 + {3'b000, diff};
    srtt_sum   = {smoothed_rtt, 3'b000} - {3'b000, smoothed_rtt}
                 + {3'b000, sample};
    if (smoothed_rtt == 32'd0) begin
      srtt_upd = sample;
      var_upd  = {1'b0, sample[31:1]};
    end else begin
      srtt_upd = srtt_sum[34:3];
      var_upd  = var_sum[33:2];
    end
    rto_sum    = {3'b000, srtt_upd} + {1'b0, var_upd, 2'b00};
    rto_double = {2'b00, timeout_value, 1'b0};

    smoothed_rtt_next       = smoothed_rtt;
    rtt_variance_next       = rtt_variance;
    timeout_value_next      = timeout_value;
    probe_valid_next        = probe_valid;
    probe_end_sequence_next = probe_end_sequence;
    probe_timestamp_next    = probe_timestamp;
    retransmitting_next     = retransmitting;
    took                    = 1'b0;

    case (s1_op)
      tre_pkg::OP_RESET: begin
        smoothed_rtt_next       = 32'd0;
        rtt_variance_next       = 32'd0;
        timeout_value_next      = rto_initial_ms;
        probe_valid_next        = 1'b0;
        probe_end_sequence_next = 32'd0;
        probe_timestamp_next    = 32'd0;
        retransmitting_next     = 1'b0;
      end
      tre_pkg::OP_TRANSMIT: begin
        if (timestamps_enabled && !retransmitting && !probe_valid) begin
          probe_end_sequence_next = s1_end_seq;
          probe_timestamp_next    = s1_tsval;
          probe_valid_next        = 1'b1;
        end
      end
      tre_pkg::OP_ACK: begin
        if (ack_ok) begin
          took               = 1'b1;
          smoothed_rtt_next  = srtt_upd;
          rtt_variance_next  = var_upd;
          timeout_value_next = tre_pkg::clamp_rto(rto_sum, rto_min_ms, rto_max_ms);
          probe_valid_next   = 1'b0;
        end
      end
      tre_pkg::OP_TIMEOUT: begin
        timeout_value_next  = tre_pkg::clamp_rto(rto_double, rto_min_ms, rto_max_ms);
        probe_valid_next    = 1'b0;
        retransmitting_next = 1'b1;
      end
      tre_pkg::OP_RETRANSMIT: begin
        probe_valid_next    = 1'b0;
        retransmitting_next = 1'b1;
      end
      tre_pkg::OP_FLIGHT_ACK: begin
        probe_valid_next    = 1'b0;
        retransmitting_next = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed_rtt       <= 32'd0;
      rtt_variance       <= 32'd0;
      timeout_value      <= tre_pkg::RTO_INITIAL_RESET;
      probe_valid        <= 1'b0;
      probe_end_sequence <= 32'd0;
      probe_timestamp    <= 32'd0;
      retransmitting     <= 1'b0;
    end else if (advance) begin
      smoothed_rtt       <= smoothed_rtt_next;
      rtt_variance       <= rtt_variance_next;
      timeout_value      <= timeout_value_next;
      probe_valid        <= probe_valid_next;
      probe_end_sequence <= probe_end_sequence_next;
      probe_timestamp    <= probe_timestamp_next;
      retransmitting     <= retransmitting_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sample_taken  <= took;
      rto_out_ms    <= timeout_value_next;
      srtt_out_ms   <= smoothed_rtt_next;
      rttvar_out_ms <= rtt_variance_next;
      in_retransmit <= retransmitting_next;
      probe_armed   <= probe_valid_next;
    end
  end

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // no package names for the two undefined operation codes
  localparam tre_pkg::op_t OP_UNDEF_LO = 3'd6;
  localparam tre_pkg::op_t OP_UNDEF_HI = 3'd7;

  typedef struct packed {
    tre_pkg::op_t op;
    logic [31:0] end_seq;
    logic [31:0] tsval;
    logic [31:0] ack;
    logic        echo;
    logic [31:0] tsecr;
    logic [31:0] now;
  } tcp_evt_t;

  typedef struct packed {
    logic        sample_taken;
    logic [31:0] rto;
    logic [31:0] srtt;
    logic [31:0] rttvar;
    logic        karn;
    logic        probe;
  } rto_report_t;

  typedef enum logic {ROW_EVENT, ROW_CONFIG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    tcp_evt_t    ev;
    logic        typed;
    rto_report_t want;
    logic        ts;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] init;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  tre_pkg::reg_index_t cfg_index = tre_pkg::REG_TS_ENABLED;
  logic [31:0] cfg_data = '0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  tre_pkg::op_t operation = tre_pkg::OP_RESET;
  logic [31:0] segment_end_seq = '0;
  logic [31:0] segment_tsval = '0;
  logic [31:0] ack_number = '0;
  logic        echo_present = 1'b0;
  logic [31:0] echo_tsecr = '0;
  logic [31:0] now_ms = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        sample_taken;
  logic [31:0] rto_out_ms;
  logic [31:0] srtt_out_ms;
  logic [31:0] rttvar_out_ms;
  logic        in_retransmit;
  logic        probe_armed;

  // estimator copy kept by the bench
  logic        conf_ts;
  logic [31:0] conf_min, conf_max, conf_init;
  logic [31:0] est_srtt, est_rttvar, est_rto;
  logic        probe_live, karn_hold;
  logic [31:0] probe_seq, probe_ts;

  rto_report_t expected_reports[$];
  int          errors = 0;
  logic        calm = 1'b0;

  tcp_rto_estimator_unit dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .operation      (operation),
    .segment_end_seq(segment_end_seq),
    .segment_tsval  (segment_tsval),
    .ack_number     (ack_number),
    .echo_present   (echo_present),
    .echo_tsecr     (echo_tsecr),
    .now_ms         (now_ms),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .sample_taken   (sample_taken),
    .rto_out_ms     (rto_out_ms),
    .srtt_out_ms    (srtt_out_ms),
    .rttvar_out_ms  (rttvar_out_ms),
    .in_retransmit  (in_retransmit),
    .probe_armed    (probe_armed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // lower bound is tested first: when the bounds cross it wins for values below it, others get the upper bound
  function automatic logic [31:0] clamp_timeout(input logic [63:0] v);
    if (v < {32'd0, conf_min}) begin
      return conf_min;
    end else if (v > {32'd0, conf_max}) begin
      return conf_max;
    end
    return v[31:0];
  endfunction

  task automatic estimate_rto(input tcp_evt_t e, output rto_report_t r);
    logic [31:0] rtt, diff, reach;
    logic [63:0] wide;
    r = '0;
    case (e.op)
      tre_pkg::OP_RESET: begin
        est_srtt = '0;
        est_rttvar = '0;
        est_rto = conf_init;
        probe_live = 1'b0;
        probe_seq = '0;
        probe_ts = '0;
        karn_hold = 1'b0;
      end
      tre_pkg::OP_TRANSMIT: begin
        if (conf_ts && !karn_hold && !probe_live) begin
          probe_seq = e.end_seq;
          probe_ts = e.tsval;
          probe_live = 1'b1;
        end
      end
      tre_pkg::OP_ACK: begin
        reach = e.ack - probe_seq;
        if (conf_ts && e.echo && probe_live && !karn_hold && e.tsecr == probe_ts &&
            !reach[31]) begin
          rtt = e.now - e.tsecr;
          if (rtt == 32'd0) rtt = 32'd1;
          if (est_srtt == 32'd0) begin
            est_srtt = rtt;
            est_rttvar = rtt >> 1;
          end else begin
            diff = (est_srtt > rtt) ? est_srtt - rtt : rtt - est_srtt;
            wide = ({32'd0, est_rttvar} * 64'd3 + {32'd0, diff}) >> 2;
            est_rttvar = wide[31:0];
            wide = ({32'd0, est_srtt} * 64'd7 + {32'd0, rtt}) >> 3;
            est_srtt = wide[31:0];
          end
          est_rto = clamp_timeout({32'd0, est_srtt} + ({32'd0, est_rttvar} << 2));
          probe_live = 1'b0;
          r.sample_taken = 1'b1;
        end
      end
      tre_pkg::OP_TIMEOUT: begin
        est_rto = clamp_timeout({31'd0, est_rto, 1'b0});
        probe_live = 1'b0;
        karn_hold = 1'b1;
      end
      tre_pkg::OP_RETRANSMIT: begin
        probe_live = 1'b0;
        karn_hold = 1'b1;
      end
      tre_pkg::OP_FLIGHT_ACK: begin
        probe_live = 1'b0;
        karn_hold = 1'b0;
      end
      default: ;
    endcase
    r.rto = est_rto;
    r.srtt = est_srtt;
    r.rttvar = est_rttvar;
    r.karn = karn_hold;
    r.probe = probe_live;
  endtask

  // mostly well-formed probe/ack exchanges, the rest noise
  function automatic tcp_evt_t random_event();
    tcp_evt_t e;
    logic [31:0] rtt;
    int sel;
    e.op = tre_pkg::op_t'($urandom_range(7));
    e.end_seq = $urandom;
    e.tsval = $urandom;
    e.ack = $urandom;
    e.echo = 1'($urandom_range(1));
    e.tsecr = $urandom;
    e.now = $urandom;
    sel = $urandom_range(99);
    if (karn_hold && sel < 40) begin
      e.op = tre_pkg::OP_FLIGHT_ACK;
    end else if (!probe_live && sel < 60) begin
      e.op = tre_pkg::OP_TRANSMIT;
    end else if (probe_live && sel < 75) begin
      e.op = tre_pkg::OP_ACK;
      e.echo = ($urandom_range(19) != 0);
      e.tsecr = ($urandom_range(15) != 0) ? probe_ts
                                           : probe_ts ^ (32'd1 << $urandom_range(31));
      case ($urandom_range(9))
        0: e.ack = probe_seq - 32'd1 - $urandom_range(100);
        1: e.ack = probe_seq + 32'h7FFFFFFF;
        2: e.ack = probe_seq + 32'h80000000;
        default: e.ack = probe_seq + $urandom_range(3000);
      endcase
      case ($urandom_range(9))
        0: rtt = '0;
        1: rtt = $urandom;
        default: rtt = $urandom_range(2000, 1);
      endcase
      e.now = e.tsecr + rtt;
    end
    return e;
  endfunction

  function automatic plan_row_t stim(input tre_pkg::op_t op, input logic [31:0] seq, tsv, ack,
                                     input logic echo, input logic [31:0] tsecr, now);
    plan_row_t r;
    r = '0;
    r.kind = ROW_EVENT;
    r.ev.op = op;
    r.ev.end_seq = seq;
    r.ev.tsval = tsv;
    r.ev.ack = ack;
    r.ev.echo = echo;
    r.ev.tsecr = tsecr;
    r.ev.now = now;
    return r;
  endfunction

  function automatic plan_row_t known(input plan_row_t r, input rto_report_t want);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic plan_row_t retune(input logic ts, input logic [31:0] lo, hi, init);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CONFIG;
    r.ts = ts;
    r.lo = lo;
    r.hi = hi;
    r.init = init;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  task automatic push_event(input tcp_evt_t e, input logic typed, input rto_report_t want);
    rto_report_t pred;
    if (!calm && $urandom_range(99) < 28) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    item_valid <= 1'b1;
    operation <= e.op;
    segment_end_seq <= e.end_seq;
    segment_tsval <= e.tsval;
    ack_number <= e.ack;
    echo_present <= e.echo;
    echo_tsecr <= e.tsecr;
    now_ms <= e.now;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    estimate_rto(e, pred);
    expected_reports.push_back(typed ? want : pred);
  endtask

  // hold the sender until the pipeline is empty
  task automatic settle();
    item_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic ts, input logic [31:0] lo, hi, init);
    cfg_write_en <= 1'b1;
    cfg_index <= tre_pkg::REG_TS_ENABLED;
    cfg_data <= {31'd0, ts};
    @(posedge clk);
    cfg_index <= tre_pkg::REG_RTO_MIN;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= tre_pkg::REG_RTO_MAX;
    cfg_data <= hi;
    @(posedge clk);
    cfg_index <= tre_pkg::REG_RTO_INITIAL;
    cfg_data <= init;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    conf_ts = ts;
    conf_min = lo;
    conf_max = hi;
    conf_init = init;
  endtask

  task automatic run_phase(input logic ts, input logic [31:0] lo, hi, init,
                           input int count, input logic quiet);
    settle();
    program_regs(ts, lo, hi, init);
    calm = quiet;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) settle();
      push_event(random_event(), 1'b0, '0);
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin : drain_results
    rto_report_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_reports.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          want = expected_reports.pop_front();
          check_field("sample_taken", {31'd0, want.sample_taken}, {31'd0, sample_taken});
          check_field("rto_out_ms", want.rto, rto_out_ms);
          check_field("srtt_out_ms", want.srtt, srtt_out_ms);
          check_field("rttvar_out_ms", want.rttvar, rttvar_out_ms);
          check_field("in_retransmit", {31'd0, want.karn}, {31'd0, in_retransmit});
          check_field("probe_armed", {31'd0, want.probe}, {31'd0, probe_armed});
        end
      end
      result_stall <= !calm && ($urandom_range(99) < 28);
    end
  end

  initial begin
    plan_row_t directed[$];

    conf_ts = 1'b1;
    conf_min = tre_pkg::RTO_MIN_RESET;
    conf_max = tre_pkg::RTO_MAX_RESET;
    conf_init = tre_pkg::RTO_INITIAL_RESET;
    est_srtt = '0;
    est_rttvar = '0;
    est_rto = tre_pkg::RTO_INITIAL_RESET;
    probe_live = 1'b0;
    probe_seq = '0;
    probe_ts = '0;
    karn_hold = 1'b0;

    // default bounds: probe matching rules, Karn, every operation
    directed.push_back(known(stim(tre_pkg::OP_ACK, 0, 0, 0, 1'b1, 0, 0),
                             {1'b0, tre_pkg::RTO_INITIAL_RESET, 32'd0, 32'd0, 1'b0, 1'b0}));
    directed.push_back(known(stim(tre_pkg::OP_TRANSMIT, 1000, 100, 0, 1'b0, 0, 0),
                             {1'b0, tre_pkg::RTO_INITIAL_RESET, 32'd0, 32'd0, 1'b0, 1'b1}));
    directed.push_back(known(stim(tre_pkg::OP_TRANSMIT, 5000, 7, 0, 1'b0, 0, 0),
                             {1'b0, tre_pkg::RTO_INITIAL_RESET, 32'd0, 32'd0, 1'b0, 1'b1}));
    directed.push_back(known(stim(tre_pkg::OP_ACK, 0, 0, 1000, 1'b1, 99, 200),
                             {1'b0, tre_pkg::RTO_INITIAL_RESET, 32'd0, 32'd0, 1'b0, 1'b1}));
    directed.push_back(known(stim(tre_pkg::OP_ACK, 0, 0, 1000, 1'b0, 100, 200),
                             {1'b0, tre_pkg::RTO_INITIAL_RESET, 32'd0, 32'd0, 1'b0, 1'b1}));
    directed.push_back(known(stim(tre_pkg::OP_ACK, 0, 0, 999, 1'b1, 100, 200),
                             {1'b0, tre_pkg::RTO_INITIAL_RESET, 32'd0, 32'd0, 1'b0, 1'b1}));
    // zero RTT counts as 1 ms
    directed.push_back(known(stim(tre_pkg::OP_ACK, 0, 0, 1000, 1'b1, 100, 100),
                             {1'b1, tre_pkg::RTO_INITIAL_RESET, 32'd1, 32'd0, 1'b0, 1'b0}));
    directed.push_back(stim(tre_pkg::OP_TRANSMIT, 32'hFFFFFFF0, 32'hFFFFFFFF, 0, 1'b0, 0, 0));
    // sequence and clock both wrap
    directed.push_back(stim(tre_pkg::OP_ACK, 0, 0, 32'h7FFFFFEF, 1'b1, 32'hFFFFFFFF, 999));
    directed.push_back(stim(tre_pkg::OP_TIMEOUT, 0, 0, 0, 1'b0, 0, 0));
    directed.push_back(stim(tre_pkg::OP_TRANSMIT, 1, 2, 0, 1'b0, 0, 0));
    directed.push_back(stim(tre_pkg::OP_ACK, 0, 0, 1, 1'b1, 2, 50));
    directed.push_back(stim(tre_pkg::OP_FLIGHT_ACK, 0, 0, 0, 1'b0, 0, 0));
    directed.push_back(stim(tre_pkg::OP_RETRANSMIT, 0, 0, 0, 1'b0, 0, 0));
    directed.push_back(stim(tre_pkg::OP_FLIGHT_ACK, 0, 0, 0, 1'b0, 0, 0));
    directed.push_back(stim(OP_UNDEF_LO, 0, 0, 0, 1'b0, 0, 0));
    directed.push_back(stim(OP_UNDEF_HI, '1, '1, '1, 1'b1, '1, '1));
    directed.push_back(known(stim(tre_pkg::OP_RESET, 0, 0, 0, 1'b0, 0, 0),
                             {1'b0, tre_pkg::RTO_INITIAL_RESET, 32'd0, 32'd0, 1'b0, 1'b0}));
    // widest bounds, full-scale samples
    directed.push_back(retune(1'b1, 32'd1, 32'hFFFFFFFF, 32'hFFFFFFFF));
    directed.push_back(known(stim(tre_pkg::OP_RESET, 0, 0, 0, 1'b0, 0, 0),
                             {1'b0, 32'hFFFFFFFF, 32'd0, 32'd0, 1'b0, 1'b0}));
    directed.push_back(known(stim(tre_pkg::OP_TIMEOUT, 0, 0, 0, 1'b0, 0, 0),
                             {1'b0, 32'hFFFFFFFF, 32'd0, 32'd0, 1'b1, 1'b0}));
    directed.push_back(known(stim(tre_pkg::OP_FLIGHT_ACK, 0, 0, 0, 1'b0, 0, 0),
                             {1'b0, 32'hFFFFFFFF, 32'd0, 32'd0, 1'b0, 1'b0}));
    directed.push_back(known(stim(tre_pkg::OP_TRANSMIT, 0, 0, 0, 1'b0, 0, 0),
                             {1'b0, 32'hFFFFFFFF, 32'd0, 32'd0, 1'b0, 1'b1}));
    directed.push_back(stim(tre_pkg::OP_ACK, 0, 0, 0, 1'b1, 0, 32'hFFFFFFFF));
    directed.push_back(stim(tre_pkg::OP_TRANSMIT, 32'hFFFFFFFF, 5, 0, 1'b0, 0, 0));
    directed.push_back(stim(tre_pkg::OP_ACK, 0, 0, 32'hFFFFFFFF, 1'b1, 5, 4));
    // crossed bounds with timestamps off
    directed.push_back(retune(1'b0, 32'd5000, 32'd10, 32'd1));
    directed.push_back(known(stim(tre_pkg::OP_RESET, 0, 0, 0, 1'b0, 0, 0),
                             {1'b0, 32'd1, 32'd0, 32'd0, 1'b0, 1'b0}));
    directed.push_back(known(stim(tre_pkg::OP_TRANSMIT, 3, 4, 0, 1'b0, 0, 0),
                             {1'b0, 32'd1, 32'd0, 32'd0, 1'b0, 1'b0}));
    directed.push_back(known(stim(tre_pkg::OP_TIMEOUT, 0, 0, 0, 1'b0, 0, 0),
                             {1'b0, 32'd5000, 32'd0, 32'd0, 1'b1, 1'b0}));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CONFIG) begin
        settle();
        program_regs(directed[i].ts, directed[i].lo, directed[i].hi, directed[i].init);
      end else begin
        push_event(directed[i].ev, directed[i].typed, directed[i].want);
      end
    end

    run_phase(1'b1, tre_pkg::RTO_MIN_RESET, tre_pkg::RTO_MAX_RESET,
              tre_pkg::RTO_INITIAL_RESET, 300, 1'b0);
    run_phase(1'b1, 32'd1, 32'hFFFFFFFF, 32'd3, 300, 1'b0);
    run_phase(1'b1, 32'd200, 32'd2000, 32'hFFFFFFFF, 300, 1'b1);
    run_phase(1'b0, 32'd1000, 32'd60000, 32'd500, 100, 1'b0);
    run_phase(1'b1, 32'd3000, 32'd100, 32'd50, 200, 1'b0);
    run_phase(1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd1, 150, 1'b0);
    run_phase(1'b1, 32'd1, 32'd1, 32'hFFFFFFFF, 150, 1'b0);

    settle();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
